[rtl/core/pnz_pkg.sv]
package pnz_pkg;

  localparam int COORD_W          = 32;
  localparam int NOISE_W          = 16;
  localparam int COORD_FRAC_BITS  = 16;
  localparam int RESULT_FRAC_BITS = 15;
  localparam int GRAD_FRAC        = 15;
  localparam int DOT_FRAC         = 30;
  localparam int CELL_BITS        = 4;
  localparam int CELLS            = 2 ** CELL_BITS;

  localparam int T_W = COORD_FRAC_BITS;
  localparam int D_W = T_W + 1;
  localparam int G_W = GRAD_FRAC + 2;
  localparam int P_W = G_W + D_W + 1;

  localparam int PROD_FRAC = GRAD_FRAC + COORD_FRAC_BITS;
  localparam int DOT_RSH   = (PROD_FRAC >= DOT_FRAC) ? PROD_FRAC - DOT_FRAC : 0;
  localparam int DOT_LSH   = (PROD_FRAC < DOT_FRAC) ? DOT_FRAC - PROD_FRAC : 0;
  localparam int N_W       = P_W - DOT_RSH + DOT_LSH;

  localparam int W_W  = T_W + 1;
  localparam int Q_W  = T_W + 5;
  localparam int BL_W = N_W + W_W + 2;

  localparam int RND_SH = DOT_FRAC - RESULT_FRAC_BITS;
  localparam int LAT    = 8;

  localparam int FADE_C5 = 6;
  localparam int FADE_C4 = 15;
  localparam int FADE_C3 = 10;

  typedef logic [CELL_BITS-1:0]       cell_t;
  typedef logic [T_W-1:0]             frac_t;
  typedef logic [W_W-1:0]             weight_t;
  typedef logic signed [G_W-1:0]      grad_t;
  typedef logic signed [D_W-1:0]      delta_t;
  typedef logic signed [P_W-1:0]      prod_t;
  typedef logic signed [N_W-1:0]      dot_t;

  typedef struct packed {
    dot_t n00;
    dot_t n10;
    dot_t n01;
    dot_t n11;
  } corner_t;

  localparam weight_t FADE_ONE = weight_t'(1) << T_W;

  localparam cell_t PERM [CELLS] = '{
    4'd6, 4'd4, 4'd12, 4'd7, 4'd10, 4'd1, 4'd3, 4'd9,
    4'd0, 4'd14, 4'd13, 4'd5, 4'd15, 4'd8, 4'd2, 4'd11
  };

  localparam grad_t GRAD_X [CELLS] = '{
    17'sd32768, 17'sd30274, 17'sd23170, 17'sd12540,
    17'sd0, -17'sd12540, -17'sd23170, -17'sd30274,
    -17'sd32768, -17'sd30274, -17'sd23170, -17'sd12540,
    17'sd0, 17'sd12540, 17'sd23170, 17'sd30274
  };

  localparam grad_t GRAD_Y [CELLS] = '{
    17'sd0, 17'sd12540, 17'sd23170, 17'sd30274,
    17'sd32768, 17'sd30274, 17'sd23170, 17'sd12540,
    17'sd0, -17'sd12540, -17'sd23170, -17'sd30274,
    -17'sd32768, -17'sd30274, -17'sd23170, -17'sd12540
  };

endpackage

[rtl/core/pnz_channels.sv]
interface pnz_coord_if;
  import pnz_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] coord_x;
  logic signed [COORD_W-1:0] coord_y;

  modport source (output valid, output coord_x, output coord_y, input ready);
  modport sink (input valid, input coord_x, input coord_y, output ready);
endinterface

interface pnz_noise_if;
  import pnz_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [NOISE_W-1:0] noise_value;

  modport source (output valid, output noise_value, input ready);
  modport sink (input valid, input noise_value, output ready);
endinterface

[rtl/core/pnz_lattice.sv]
module pnz_lattice (
  input  logic                               clk,
  input  logic                               en,
  input  logic signed [pnz_pkg::COORD_W-1:0] coord_x,
  input  logic signed [pnz_pkg::COORD_W-1:0] coord_y,
  output pnz_pkg::corner_t                   corner
);
  import pnz_pkg::*;

  cell_t   cx, cy, r0, r1, i00, i10, i01, i11;
  cell_t   g00_r, g10_r, g01_r, g11_r;
  frac_t   tx_r, ty_r;
  delta_t  dx0, dx1, dy0, dy1;
  prod_t   p00_r, p10_r, p01_r, p11_r;
  corner_t corner_r;

  function automatic prod_t dot2(input cell_t g, input delta_t dx, input delta_t dy);
    logic signed [G_W+D_W-1:0] mx;
    logic signed [G_W+D_W-1:0] my;
    mx = GRAD_X[g] * dx;
    my = GRAD_Y[g] * dy;
    return P_W'(mx) + P_W'(my);
  endfunction

  function automatic dot_t to_dot(input prod_t p);
    logic signed [P_W+DOT_LSH-1:0] e;
    e = (P_W + DOT_LSH)'(p);
    e = e <<< DOT_LSH;
    return dot_t'(e >>> DOT_RSH);
  endfunction

  // Cell hash: the permutation of the row index offsets the column index.
  always_comb begin
    cx  = coord_x[COORD_FRAC_BITS +: CELL_BITS];
    cy  = coord_y[COORD_FRAC_BITS +: CELL_BITS];
    r0  = PERM[cy];
    r1  = PERM[cy + cell_t'(1)];
    i00 = cx + r0;
    i10 = cx + cell_t'(1) + r0;
    i01 = cx + r1;
    i11 = cx + cell_t'(1) + r1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g00_r <= PERM[i00];
      g10_r <= PERM[i10];
      g01_r <= PERM[i01];
      g11_r <= PERM[i11];
      tx_r  <= coord_x[T_W-1:0];
      ty_r  <= coord_y[T_W-1:0];
    end
  end

  // The far corner offset t - 1 is the fraction with a set sign bit on top.
  always_comb begin
    dx0 = signed'({1'b0, tx_r});
    dx1 = signed'({1'b1, tx_r});
    dy0 = signed'({1'b0, ty_r});
    dy1 = signed'({1'b1, ty_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p00_r <= dot2(g00_r, dx0, dy0);
      p10_r <= dot2(g10_r, dx1, dy0);
      p01_r <= dot2(g01_r, dx0, dy1);
      p11_r <= dot2(g11_r, dx1, dy1);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      corner_r.n00 <= to_dot(p00_r);
      corner_r.n10 <= to_dot(p10_r);
      corner_r.n01 <= to_dot(p01_r);
      corner_r.n11 <= to_dot(p11_r);
    end
  end

  assign corner = corner_r;
endmodule

[rtl/core/pnz_fade.sv]
module pnz_fade (
  input  logic             clk,
  input  logic             en,
  input  pnz_pkg::frac_t   t,
  output pnz_pkg::weight_t w
);
  import pnz_pkg::*;

  localparam logic [Q_W-1:0] Q_BIAS = Q_W'(FADE_C3) << T_W;

  logic [2*T_W-1:0] sq_r, cu_r;
  frac_t            ta_r, tb_r, t2b_r, t2, t3;
  logic [Q_W-1:0]   q;
  logic [T_W+Q_W-1:0] fp_r;

  assign t2 = sq_r[2*T_W-1:T_W];
  assign t3 = cu_r[2*T_W-1:T_W];
  assign q  = Q_W'(t2b_r) * Q_W'(FADE_C5) + Q_BIAS - Q_W'(tb_r) * Q_W'(FADE_C4);

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r  <= t * t;
      ta_r  <= t;
      cu_r  <= t2 * ta_r;
      t2b_r <= t2;
      tb_r  <= ta_r;
      fp_r  <= t3 * q;
    end
  end

  assign w = fp_r[T_W +: W_W];
endmodule

[rtl/core/pnz_blend.sv]
module pnz_blend (
  input  logic             clk,
  input  logic             en,
  input  pnz_pkg::dot_t    a,
  input  pnz_pkg::dot_t    b,
  input  pnz_pkg::weight_t w,
  output pnz_pkg::dot_t    m
);
  import pnz_pkg::*;

  logic signed [W_W:0]     wa, wb;
  logic signed [N_W+W_W:0] pa_r, pb_r;
  logic signed [BL_W-1:0]  sum;
  dot_t                    m_r;

  assign wa  = signed'({1'b0, FADE_ONE - w});
  assign wb  = signed'({1'b0, w});
  assign sum = BL_W'(pa_r) + BL_W'(pb_r);

  // The weighted sum is a convex mix of a and b, so it fits back into a dot width.
  always_ff @(posedge clk) begin
    if (en) begin
      pa_r <= wa * a;
      pb_r <= wb * b;
      m_r  <= dot_t'(sum >>> T_W);
    end
  end

  assign m = m_r;
endmodule

[rtl/core/perlin_noise_2d.sv]
// Two-dimensional gradient noise. Each request carries one point with 16 fraction
// bits per coordinate and yields one signed Q1.15 noise value; the lattice repeats
// every 16 cells. The block is an eight-stage pipeline that takes one request per
// clock while the output is not held. While a result waits at the output, the
// whole pipeline holds and the input is not ready.
module perlin_noise_2d (
  input logic               clk,
  input logic               rst_n,
  pnz_coord_if.sink         in_coord,
  pnz_noise_if.source       out_noise
);
  import pnz_pkg::*;

  localparam logic signed [N_W:0] RND_HALF = (N_W + 1)'(1) <<< (RND_SH - 1);
  localparam logic signed [N_W:0] SAT_MAX  = (N_W + 1)'(2 ** (NOISE_W - 1) - 1);
  localparam logic signed [N_W:0] SAT_MIN  = (N_W + 1)'(-(2 ** (NOISE_W - 1)));

  logic                      en;
  logic [LAT-1:0]            vld_r, vld_nxt;
  corner_t                   corner;
  weight_t                   wx, wy, wy_d1_r, wy_d2_r;
  dot_t                      nx0, nx1, nxy;
  logic signed [N_W:0]       rsum, rq;
  logic signed [NOISE_W-1:0] noise_r, noise_nxt;

  assign en             = !vld_r[LAT-1] || out_noise.ready;
  assign in_coord.ready = en;

  assign vld_nxt = en ? {vld_r[LAT-2:0], in_coord.valid} : vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  pnz_lattice u_lattice (
    .clk     (clk),
    .en      (en),
    .coord_x (in_coord.coord_x),
    .coord_y (in_coord.coord_y),
    .corner  (corner)
  );

  pnz_fade u_fade_x (
    .clk (clk),
    .en  (en),
    .t   (in_coord.coord_x[T_W-1:0]),
    .w   (wx)
  );

  pnz_fade u_fade_y (
    .clk (clk),
    .en  (en),
    .t   (in_coord.coord_y[T_W-1:0]),
    .w   (wy)
  );

  pnz_blend u_blend_x0 (
    .clk (clk),
    .en  (en),
    .a   (corner.n00),
    .b   (corner.n10),
    .w   (wx),
    .m   (nx0)
  );

  pnz_blend u_blend_x1 (
    .clk (clk),
    .en  (en),
    .a   (corner.n01),
    .b   (corner.n11),
    .w   (wx),
    .m   (nx1)
  );

  // The y weight waits while the two x blends run.
  always_ff @(posedge clk) begin
    if (en) begin
      wy_d1_r <= wy;
      wy_d2_r <= wy_d1_r;
    end
  end

  pnz_blend u_blend_y (
    .clk (clk),
    .en  (en),
    .a   (nx0),
    .b   (nx1),
    .w   (wy_d2_r),
    .m   (nxy)
  );

  // Round to nearest with ties upward, then clamp to the output range.
  always_comb begin
    rsum = (N_W + 1)'(nxy) + RND_HALF;
    rq   = rsum >>> RND_SH;
    if (rq > SAT_MAX) begin
      noise_nxt = NOISE_W'(SAT_MAX);
    end else if (rq < SAT_MIN) begin
      noise_nxt = NOISE_W'(SAT_MIN);
    end else begin
      noise_nxt = NOISE_W'(rq);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      noise_r <= noise_nxt;
    end
  end

  assign out_noise.valid       = vld_r[LAT-1];
  assign out_noise.noise_value = noise_r;

`ifndef NO_ASSERTIONS
  a_fade_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[2] |-> (wx <= FADE_ONE && wy <= FADE_ONE))
    else $error("fade weight exceeds one");

  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_noise.valid)
    else $error("pipeline not flushed by reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(vld_r) && $stable(noise_r)))
    else $error("pipeline moved while stalled");
`endif
endmodule

[verif/perlin_noise_2d_tb.sv]
module perlin_noise_2d_tb;
  import pnz_pkg::*;

  localparam int     RANDOM_POINTS = 1030;
  localparam int     HOLD_AT       = 400;
  localparam int     HOLD_CYCLES   = 300;
  localparam int     STALL_LIMIT   = 2000;
  localparam int     DOT_DROP      = 15 + COORD_FRAC_BITS - 30;
  localparam int     ROUND_DROP    = 30 - 15;
  localparam longint ONE_T         = longint'(1) << COORD_FRAC_BITS;

  localparam int LATTICE_PERM [16] = '{6, 4, 12, 7, 10, 1, 3, 9, 0, 14, 13, 5, 15, 8, 2, 11};
  localparam int DIR_X [16] = '{32768, 30274, 23170, 12540, 0, -12540, -23170, -30274,
                                -32768, -30274, -23170, -12540, 0, 12540, 23170, 30274};
  localparam int DIR_Y [16] = '{0, 12540, 23170, 30274, 32768, 30274, 23170, 12540,
                                0, -12540, -23170, -30274, -32768, -30274, -23170, -12540};

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    int                        gap;
    bit                        drain;
  } point_req_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  pnz_coord_if coord_ch ();
  pnz_noise_if noise_ch ();

  perlin_noise_2d dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_coord (coord_ch),
    .out_noise(noise_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  point_req_t                pending_points [$];
  logic signed [NOISE_W-1:0] expected_noise [$];
  int                        n_requests = 0;
  int                        n_results = 0;
  int                        mismatches = 0;
  int                        idle_cycles = 0;
  int                        stall_left = 0;
  int                        hold_left = 0;
  bit                        rx_steady = 1'b0;
  bit                        hold_done = 1'b0;

  function automatic longint slope_dot(input logic [3:0] g, input longint dx, input longint dy);
    return (DIR_X[g] * dx + DIR_Y[g] * dy) >>> DOT_DROP;
  endfunction

  function automatic longint smooth_step5(input longint t);
    longint t2, t3, q;
    t2 = (t * t) >> COORD_FRAC_BITS;
    t3 = (t2 * t) >> COORD_FRAC_BITS;
    q  = 6 * t2 + 10 * ONE_T - 15 * t;
    return (t3 * q) >> COORD_FRAC_BITS;
  endfunction

  function automatic longint lerp_fixed(input longint a, input longint b, input longint w);
    return ((ONE_T - w) * a + w * b) >>> COORD_FRAC_BITS;
  endfunction

  function automatic logic signed [NOISE_W-1:0] gradient_noise(
      input logic signed [COORD_W-1:0] px_in, input logic signed [COORD_W-1:0] py_in);
    logic [3:0] cx, cy, row0, row1, idx, g00, g10, g01, g11;
    longint     tx, ty, n00, n10, n01, n11, u, v, nx0, nx1, nxy, r;
    cx   = px_in[COORD_FRAC_BITS +: 4];
    cy   = py_in[COORD_FRAC_BITS +: 4];
    tx   = longint'(px_in[COORD_FRAC_BITS-1:0]);
    ty   = longint'(py_in[COORD_FRAC_BITS-1:0]);
    row0 = 4'(LATTICE_PERM[cy]);
    idx  = cy + 4'd1;
    row1 = 4'(LATTICE_PERM[idx]);
    idx  = cx + row0;
    g00  = 4'(LATTICE_PERM[idx]);
    idx  = cx + row0 + 4'd1;
    g10  = 4'(LATTICE_PERM[idx]);
    idx  = cx + row1;
    g01  = 4'(LATTICE_PERM[idx]);
    idx  = cx + row1 + 4'd1;
    g11  = 4'(LATTICE_PERM[idx]);
    n00  = slope_dot(g00, tx, ty);
    n10  = slope_dot(g10, tx - ONE_T, ty);
    n01  = slope_dot(g01, tx, ty - ONE_T);
    n11  = slope_dot(g11, tx - ONE_T, ty - ONE_T);
    u    = smooth_step5(tx);
    v    = smooth_step5(ty);
    nx0  = lerp_fixed(n00, n10, u);
    nx1  = lerp_fixed(n01, n11, u);
    nxy  = lerp_fixed(nx0, nx1, v);
    r    = (nxy + (longint'(1) << (ROUND_DROP - 1))) >>> ROUND_DROP;
    if (r > 32767) begin
      r = 32767;
    end else if (r < -32768) begin
      r = -32768;
    end
    return NOISE_W'(r);
  endfunction

  function automatic logic signed [COORD_W-1:0] boundary_coord();
    logic [15:0] fracs [5];
    fracs = '{16'h0000, 16'h0001, 16'hfffe, 16'hffff, 16'h8000};
    return {16'($urandom), fracs[$urandom_range(0, 4)]};
  endfunction

  task automatic add_point(input logic signed [COORD_W-1:0] x, input logic signed [COORD_W-1:0] y,
                           input int gap, input bit drain);
    point_req_t req;
    req.x     = x;
    req.y     = y;
    req.gap   = gap;
    req.drain = drain;
    pending_points.push_back(req);
  endtask

  always @(posedge clk) begin
    point_req_t req;
    bit         took;
    if (!rst_n) begin
      coord_ch.valid <= 1'b0;
    end else begin
      took = coord_ch.valid && coord_ch.ready;
      if (took) begin
        expected_noise.push_back(gradient_noise(coord_ch.coord_x, coord_ch.coord_y));
        n_requests <= n_requests + 1;
      end
      if (!coord_ch.valid || took) begin
        if (pending_points.size() == 0) begin
          coord_ch.valid <= 1'b0;
        end else if (pending_points[0].drain && (n_requests + int'(took) != n_results)) begin
          coord_ch.valid <= 1'b0;
        end else if (pending_points[0].gap > 0) begin
          pending_points[0].gap = pending_points[0].gap - 1;
          coord_ch.valid   <= 1'b0;
          coord_ch.coord_x <= $urandom;
          coord_ch.coord_y <= $urandom;
        end else begin
          req = pending_points.pop_front();
          coord_ch.valid   <= 1'b1;
          coord_ch.coord_x <= req.x;
          coord_ch.coord_y <= req.y;
        end
      end
    end
  end

  always @(posedge clk) begin
    logic signed [NOISE_W-1:0] want;
    if (!rst_n) begin
      noise_ch.ready <= 1'b0;
    end else begin
      if (noise_ch.valid && noise_ch.ready) begin
        if (expected_noise.size() == 0) begin
          $error("noise_value: no request outstanding, expected none, actual %0d",
                 noise_ch.noise_value);
          mismatches++;
        end else begin
          want = expected_noise.pop_front();
          if (noise_ch.noise_value !== want) begin
            $error("noise_value: expected %0d, actual %0d", want, noise_ch.noise_value);
            mismatches++;
          end
        end
        n_results <= n_results + 1;
        if (n_results % 50 == 0) begin
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        stall_left = rx_steady ? 0 : $urandom_range(0, 11);
        if (n_results >= HOLD_AT && !hold_done) begin
          hold_left = HOLD_CYCLES;
          hold_done = 1'b1;
        end
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (stall_left > 0) begin
        stall_left--;
      end
      noise_ch.ready <= (hold_left == 0 && stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else if ((coord_ch.valid && coord_ch.ready) || (noise_ch.valid && noise_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic signed [COORD_W-1:0] rx, ry;
    bit                        burst;
    coord_ch.valid   = 1'b0;
    coord_ch.coord_x = '0;
    coord_ch.coord_y = '0;
    noise_ch.ready   = 1'b0;

    add_point(32'sh0000_0000, 32'sh0000_0000, $urandom_range(0, 11), 1'b0);
    add_point(32'sh7fff_ffff, 32'sh7fff_ffff, $urandom_range(0, 11), 1'b0);
    add_point(32'sh8000_0000, 32'sh8000_0000, $urandom_range(0, 11), 1'b0);
    add_point(32'sh7fff_ffff, 32'sh8000_0000, $urandom_range(0, 11), 1'b0);
    add_point(32'sh8000_0000, 32'sh7fff_ffff, $urandom_range(0, 11), 1'b0);
    add_point(32'shffff_ffff, 32'shffff_ffff, $urandom_range(0, 11), 1'b0);
    add_point(32'sh0000_ffff, 32'sh000f_0000, $urandom_range(0, 11), 1'b0);
    add_point(32'sh0010_0000, 32'shffff_0000, $urandom_range(0, 11), 1'b0);
    for (int k = 0; k < 16; k++) begin
      rx = ($urandom & 32'hfff0_0000) | (k << COORD_FRAC_BITS) | $urandom_range(0, 65535);
      ry = ($urandom & 32'hfff0_0000) | ((15 - k) << COORD_FRAC_BITS) | $urandom_range(0, 65535);
      add_point(rx, ry, $urandom_range(0, 11), 1'b0);
    end

    burst = 1'b0;
    for (int i = 0; i < RANDOM_POINTS; i++) begin
      if (i % 40 == 0) begin
        burst = ($urandom_range(0, 2) == 0);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          rx = $urandom;
          ry = $urandom;
        end
        6, 7: begin
          rx = boundary_coord();
          ry = boundary_coord();
        end
        default: begin
          rx = $urandom_range(0, 32'h3ffff) - 32'h20000;
          ry = $urandom_range(0, 32'h3ffff) - 32'h20000;
        end
      endcase
      add_point(rx, ry, burst ? 0 : $urandom_range(0, 11), i == 0 || i == 450 || i == 850);
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_points.size() != 0 || coord_ch.valid) begin
      @(posedge clk);
    end
    while (expected_noise.size() != 0) begin
      @(posedge clk);
    end
    repeat (4 * LAT) @(posedge clk);

    $display("Sent %0d points (range extremes, every lattice cell, wrap-around, negative and",
             n_requests);
    $display("near-boundary coordinates) and checked %0d noise values under random back-pressure.",
             n_results);
    if (mismatches == 0 && expected_noise.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
